>>> rtl/rms_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the region-of-interest mean saturation block.
// Used by every module under rtl; depends on nothing else.
package rms_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int DIM_W       = 13;
	localparam int FRAC_W      = 17;
	localparam int FRAC_SHIFT  = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int CHAN_W      = 8;
	localparam int SAT_W       = 17;
	localparam int SUM_W       = 41;
	localparam int CNT_W       = 25;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_RIGHT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_BOTTOM   = 3'd5;

	localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd320;
	localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd240;
	localparam logic [FRAC_W-1:0] FRAC_ZERO        = 17'd0;
	localparam logic [FRAC_W-1:0] FRAC_ONE         = 17'd65536;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              frame_end;
	} pix_in_t;

	typedef struct packed {
		logic [SAT_W-1:0] mean_saturation;
		logic             status;
	} res_t;

	// One classified pixel as it travels from the front to the back.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              in_roi;
		logic              last;
	} fe_entry_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] num;
		logic [CNT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SAT_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SAT,
		ST_FIN,
		ST_MEAN,
		ST_OUT
	} back_state_t;

endpackage

>>> rtl/rms_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, region bounds, column/row tracking and
// classification of each accepted pixel. Depends on rms_pkg.
module rms_front #(
	parameter int MAX_WIDTH  = rms_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rms_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rms_pkg::pix_in_t                    in_data,
	input  logic                                cfg_we,
	input  logic [rms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rms_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                fifo_full,
	output logic                                push,
	output rms_pkg::fe_entry_t                  push_data
);

	localparam int WD_W   = $clog2(MAX_WIDTH + 1);
	localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int XP_W   = rms_pkg::FRAC_W + WD_W;
	localparam int YP_W   = rms_pkg::FRAC_W + HD_W;
	localparam int XB_W   = XP_W - rms_pkg::FRAC_SHIFT;
	localparam int YB_W   = YP_W - rms_pkg::FRAC_SHIFT;

	logic [rms_pkg::DIM_W-1:0]  frame_width_q, frame_height_q;
	logic [rms_pkg::FRAC_W-1:0] roi_left_q, roi_top_q, roi_right_q, roi_bottom_q;
	logic                       bnd_ok_q;
	logic [XB_W-1:0]            x0_q, x1_q;
	logic [YB_W-1:0]            y0_q, y1_q;
	logic [COL_W-1:0]           column_q;
	logic [ROW_W-1:0]           row_q;

	logic [WD_W-1:0] w_eff;
	logic [HD_W-1:0] h_eff;
	logic [XP_W-1:0] px0, px1;
	logic [YP_W-1:0] py0, py1;
	logic [XB_W-1:0] x1_c;
	logic [YB_W-1:0] y1_c;
	logic            in_roi;
	logic            col_wrap, row_wrap;
	logic            accept;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WD_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WD_W'(MAX_WIDTH);
		end else begin
			w_eff = WD_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HD_W'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = HD_W'(MAX_HEIGHT);
		end else begin
			h_eff = HD_W'(frame_height_q);
		end
	end

	assign px0 = XP_W'(roi_left_q) * XP_W'(w_eff);
	assign px1 = XP_W'(roi_right_q) * XP_W'(w_eff);
	assign py0 = YP_W'(roi_top_q) * YP_W'(h_eff);
	assign py1 = YP_W'(roi_bottom_q) * YP_W'(h_eff);

	assign x1_c = (x1_q > XB_W'(w_eff)) ? XB_W'(w_eff) : x1_q;
	assign y1_c = (y1_q > YB_W'(h_eff)) ? YB_W'(h_eff) : y1_q;

	assign in_roi = (XB_W'(column_q) >= x0_q) && (XB_W'(column_q) < x1_c) &&
			(YB_W'(row_q) >= y0_q) && (YB_W'(row_q) < y1_c);

	assign col_wrap = (WD_W'(column_q) + WD_W'(1)) >= w_eff;
	assign row_wrap = (HD_W'(row_q) + HD_W'(1)) >= h_eff;

	// The bound registers take the new configuration in the cycle after a write,
	// and input is held off until they have it.
	assign in_ready = bnd_ok_q && !fifo_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	assign push_data.red    = in_data.red;
	assign push_data.green  = in_data.green;
	assign push_data.blue   = in_data.blue;
	assign push_data.in_roi = in_roi;
	assign push_data.last   = in_data.frame_end;

	always_ff @(posedge clk) begin
		x0_q <= px0[XP_W-1:rms_pkg::FRAC_SHIFT];
		x1_q <= px1[XP_W-1:rms_pkg::FRAC_SHIFT];
		y0_q <= py0[YP_W-1:rms_pkg::FRAC_SHIFT];
		y1_q <= py1[YP_W-1:rms_pkg::FRAC_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rms_pkg::FRAME_WIDTH_RST;
			frame_height_q <= rms_pkg::FRAME_HEIGHT_RST;
			roi_left_q     <= rms_pkg::FRAC_ZERO;
			roi_top_q      <= rms_pkg::FRAC_ZERO;
			roi_right_q    <= rms_pkg::FRAC_ONE;
			roi_bottom_q   <= rms_pkg::FRAC_ONE;
			bnd_ok_q       <= 1'b0;
		end else begin
			bnd_ok_q <= !cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					rms_pkg::REG_FRAME_WIDTH: begin
						frame_width_q <= cfg_wdata[rms_pkg::DIM_W-1:0];
					end
					rms_pkg::REG_FRAME_HEIGHT: begin
						frame_height_q <= cfg_wdata[rms_pkg::DIM_W-1:0];
					end
					rms_pkg::REG_ROI_LEFT: begin
						roi_left_q <= cfg_wdata;
					end
					rms_pkg::REG_ROI_TOP: begin
						roi_top_q <= cfg_wdata;
					end
					rms_pkg::REG_ROI_RIGHT: begin
						roi_right_q <= cfg_wdata;
					end
					rms_pkg::REG_ROI_BOTTOM: begin
						roi_bottom_q <= cfg_wdata;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (in_data.frame_end) begin
				column_q <= '0;
				row_q    <= '0;
			end else if (col_wrap) begin
				column_q <= '0;
				row_q    <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				column_q <= column_q + COL_W'(1);
			end
		end
	end

endmodule

>>> rtl/rms_fifo.sv
`timescale 1ns / 1ps
// Short register queue between the front and the back end.
// Depends on rms_pkg for the entry type and depth.
module rms_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rms_pkg::fe_entry_t push_data,
	input  logic               pop,
	output rms_pkg::fe_entry_t pop_data,
	output logic               full,
	output logic               empty
);

	localparam int DEPTH = rms_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	rms_pkg::fe_entry_t entry_q [DEPTH];
	logic [AW:0]        wr_ptr_q, rd_ptr_q;

	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) && (wr_ptr_q[AW] != rd_ptr_q[AW]);
	assign pop_data = entry_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q[AW-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
			end
		end
	end

endmodule

>>> rtl/rms_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, for quotients that
// fit in SAT_W bits. Depends on rms_pkg for widths and request types.
module rms_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rms_pkg::div_req_t req,
	output rms_pkg::div_rsp_t rsp
);

	localparam int NUM_W = rms_pkg::SUM_W;
	localparam int DEN_W = rms_pkg::CNT_W;
	localparam int Q_W   = rms_pkg::SAT_W;
	localparam int CW    = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q, den_q;
	logic [Q_W-1:0]   low_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;

	logic [DEN_W:0]   trial, diff;
	logic             ge;

	// The callers guarantee the quotient fits, so the upper bits of the
	// numerator are already below the divisor and start as the remainder.
	assign trial = {rem_q, low_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	assign rsp.done = done_q;
	assign rsp.quo  = low_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DEN_W'(req.num[NUM_W-1:Q_W]);
			low_q <= req.num[Q_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/rms_back.sv
`timescale 1ns / 1ps
// Back end: takes classified pixels from the queue, computes saturation,
// accumulates, and produces the frame mean. Depends on rms_pkg and drives rms_div.
module rms_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fifo_empty,
	output logic               pop,
	input  rms_pkg::fe_entry_t pop_data,
	output rms_pkg::div_req_t  div_req,
	input  rms_pkg::div_rsp_t  div_rsp,
	output logic               out_valid,
	input  logic               out_ready,
	output rms_pkg::res_t      out_data
);

	localparam int CW = rms_pkg::CHAN_W;

	rms_pkg::back_state_t       state_q, state_d;
	rms_pkg::fe_entry_t         cur_s1;
	logic [rms_pkg::SUM_W-1:0]  sum_q;
	logic [rms_pkg::CNT_W-1:0]  count_q;
	rms_pkg::res_t              res_q;
	logic                       out_valid_q;
	rms_pkg::res_t              out_data_q;

	logic [CW-1:0]              mx, mn, rg_mx, rg_mn;
	logic                       count_ok;
	logic                       acc_en, clear, res_set;
	logic [rms_pkg::SAT_W-1:0]  acc_val;
	rms_pkg::res_t              res_d;

	always_comb begin
		rg_mx = (cur_s1.green > cur_s1.red) ? cur_s1.green : cur_s1.red;
		rg_mn = (cur_s1.green < cur_s1.red) ? cur_s1.green : cur_s1.red;
		mx    = (cur_s1.blue > rg_mx) ? cur_s1.blue : rg_mx;
		mn    = (cur_s1.blue < rg_mn) ? cur_s1.blue : rg_mn;
	end

	// Once the count saturates, later pixels are neither counted nor summed.
	assign count_ok = cur_s1.in_roi && (count_q != rms_pkg::COUNT_MAX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rms_pkg::ST_IDLE: begin
				if (!fifo_empty) begin
					state_d = rms_pkg::ST_CHECK;
				end
			end
			rms_pkg::ST_CHECK: begin
				if (count_ok && (mx != '0)) begin
					state_d = rms_pkg::ST_SAT;
				end else if (cur_s1.last) begin
					state_d = rms_pkg::ST_FIN;
				end else begin
					state_d = rms_pkg::ST_IDLE;
				end
			end
			rms_pkg::ST_SAT: begin
				if (div_rsp.done) begin
					state_d = cur_s1.last ? rms_pkg::ST_FIN : rms_pkg::ST_IDLE;
				end
			end
			rms_pkg::ST_FIN: begin
				state_d = (count_q == '0) ? rms_pkg::ST_OUT : rms_pkg::ST_MEAN;
			end
			rms_pkg::ST_MEAN: begin
				if (div_rsp.done) begin
					state_d = rms_pkg::ST_OUT;
				end
			end
			rms_pkg::ST_OUT: begin
				if (!out_valid_q) begin
					state_d = rms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rms_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop           = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = rms_pkg::SUM_W'(mx - mn) << rms_pkg::FRAC_SHIFT;
		div_req.den   = rms_pkg::CNT_W'(mx);
		acc_en        = 1'b0;
		acc_val       = div_rsp.quo;
		clear         = 1'b0;
		res_set       = 1'b0;
		res_d.mean_saturation = div_rsp.quo;
		res_d.status          = rms_pkg::STATUS_OK;
		case (state_q)
			rms_pkg::ST_IDLE: begin
				pop = !fifo_empty;
			end
			rms_pkg::ST_CHECK: begin
				if (count_ok && (mx != '0)) begin
					div_req.start = 1'b1;
				end else if (count_ok) begin
					// Black pixel: saturation is zero but the pixel still counts.
					acc_en  = 1'b1;
					acc_val = '0;
				end
			end
			rms_pkg::ST_SAT: begin
				acc_en = div_rsp.done;
			end
			rms_pkg::ST_FIN: begin
				if (count_q == '0) begin
					res_set               = 1'b1;
					res_d.mean_saturation = '0;
					res_d.status          = rms_pkg::STATUS_EMPTY;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = sum_q;
					div_req.den   = count_q;
				end
			end
			rms_pkg::ST_MEAN: begin
				res_set = div_rsp.done;
			end
			rms_pkg::ST_OUT: begin
				clear = !out_valid_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_s1 <= pop_data;
		end
		if (res_set) begin
			res_q <= res_d;
		end
		if (clear) begin
			out_data_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rms_pkg::ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (acc_en) begin
				sum_q   <= sum_q + rms_pkg::SUM_W'(acc_val);
				count_q <= count_q + rms_pkg::CNT_W'(1);
			end
			if (clear) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/roi_mean_saturation.sv
`timescale 1ns / 1ps
// Mean HSV saturation over a rectangular region of interest of a raster frame.
// Top level; depends on rms_pkg, rms_front, rms_fifo, rms_back and rms_div.
//
// Usage: pixels enter on the in_valid/in_ready channel in raster order, one
// beat per pixel, with frame_end set on the last pixel of a frame. One result
// beat leaves on out_valid/out_ready for every frame_end pixel: the mean
// saturation of the region in Q1.16, or status set when the region held no
// pixel. Registers are written through cfg_we/cfg_index/cfg_wdata while the
// block is idle; in_ready drops for the cycle after each write while the
// region bounds are recomputed.
// Throughput: the back end handles one pixel at a time. A pixel outside the
// region, or a black one, needs only the check; a pixel inside the region also
// waits for the 17-step shared divider. A frame end adds the mean division,
// when the region held pixels, and the output load. The front accepts into a
// 4-entry queue, so short bursts enter at one pixel per cycle while it has room.
// Reset clears counters, sums, queue and output and restores the register
// defaults (320 x 240, full frame). When the receiver stalls, the result holds
// in the output register, the back end waits to load the next one, and the
// queue fills until in_ready drops.
module roi_mean_saturation #(
	parameter int MAX_WIDTH  = rms_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rms_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rms_pkg::pix_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rms_pkg::res_t                  out_data,
	input  logic                           cfg_we,
	input  logic [rms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic               push, pop, fifo_full, fifo_empty;
	rms_pkg::fe_entry_t push_data, pop_data;
	rms_pkg::div_req_t  div_req;
	rms_pkg::div_rsp_t  div_rsp;

	rms_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fifo_full (fifo_full),
		.push      (push),
		.push_data (push_data)
	);

	rms_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	rms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.pop_data   (pop_data),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	rms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

>>> rtl/rms_checker.sv
`timescale 1ns / 1ps
// Port-level checks for roi_mean_saturation, attached by the bind below.
// Depends on rms_pkg and the top level's ports.
module rms_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input rms_pkg::res_t out_data,
	input logic          cfg_we
);

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// An empty region always reports a zero mean.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == rms_pkg::STATUS_EMPTY) |->
			out_data.mean_saturation == '0)
		else $error("empty-region result carries a nonzero mean");

	// A mean never exceeds 1.0 in Q1.16.
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.mean_saturation <= rms_pkg::FRAC_ONE)
		else $error("mean saturation above 1.0");

	// The bounds are stale in the cycle after a register write.
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("pixel input open while region bounds are stale");

endmodule

bind roi_mean_saturation rms_checker u_rms_checker (.*);
